### rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

    // Fixed widths of the port fields and configuration registers.
    localparam int IN_BITS    = 16;
    localparam int DELAY_W    = 18;
    localparam int FB_W       = 15;
    localparam int MIX_W      = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;

    // Gain limits, scaled by 2^15: feedback in unsigned Q0.15, mix in unsigned Q1.15.
    localparam logic [FB_W-1:0]  FEEDBACK_CAP = 15'd31129;
    localparam logic [MIX_W-1:0] MIX_ONE      = 16'd32768;

    // Configuration values after reset.
    localparam logic [DELAY_W-1:0] DELAY_RESET = 18'd24000;
    localparam logic [FB_W-1:0]    FB_RESET    = 15'd16384;
    localparam logic [MIX_W-1:0]   MIX_RESET   = 16'd9830;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_MIX      = 2'd2
    } sfd_reg_idx_t;

    // Stage enables that the control logic hands to each channel datapath.
    typedef struct packed {
        logic accept;
        logic s2_load;
        logic out_load;
    } sfd_stage_ctl_t;

endpackage

### rtl/core/sfd_ram.sv
`timescale 1ns / 1ps

module sfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port; the data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/sfd_chan.sv
`timescale 1ns / 1ps

module sfd_chan #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  sfd_pkg::sfd_stage_ctl_t              ctl,
    input  logic signed [sfd_pkg::IN_BITS-1:0]   in_sample,
    input  logic signed [SAMPLE_BITS-1:0]        mem_sample,
    input  logic                                 entry_hit,
    input  logic [sfd_pkg::FB_W-1:0]             fb_gain,
    input  logic [sfd_pkg::MIX_W-1:0]            wet_gain,
    input  logic [sfd_pkg::MIX_W-1:0]            dry_gain,
    output logic signed [SAMPLE_BITS-1:0]        store_sample,
    output logic signed [sfd_pkg::IN_BITS-1:0]   out_sample
);

    import sfd_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int XW = ((SB > IN_BITS) ? SB : IN_BITS) + 1;
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    logic signed [XW-1:0]    x_ext;
    logic signed [SB-1:0]    x_sat;
    logic signed [SB-1:0]    x_s1_reg;
    logic signed [SB-1:0]    x_s2_reg;
    logic signed [SB-1:0]    delayed;
    logic signed [SB+15:0]   p_fb_next;
    logic signed [SB+16:0]   p_wet_next;
    logic signed [SB+16:0]   p_dry_next;
    logic signed [SB+15:0]   p_fb_reg;
    logic signed [SB+16:0]   p_wet_reg;
    logic signed [SB+16:0]   p_dry_reg;
    logic signed [SB:0]      fb_term;
    logic signed [SB+1:0]    wet_term;
    logic signed [SB+1:0]    dry_term;
    logic signed [SB+1:0]    st_sum;
    logic signed [SB+2:0]    out_sum;
    logic signed [SB-1:0]    out_sat;
    logic signed [SB+15:0]   out_ext;
    logic signed [IN_BITS-1:0] out_reg;

    // Bring the input sample to the stored sample width, saturating.
    always_comb
    begin
        x_ext = XW'(in_sample);
        if (x_ext > SMAX)
        begin
            x_sat = SMAX;
        end
        else if (x_ext < SMIN)
        begin
            x_sat = SMIN;
        end
        else
        begin
            x_sat = x_ext[SB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            x_s1_reg <= x_sat;
        end
    end

    // Stage one: the delayed sample arrives from memory; form the three products.
    // A frame never written since reset reads as zero.
    assign delayed    = entry_hit ? mem_sample : '0;
    assign p_fb_next  = delayed * $signed({1'b0, fb_gain});
    assign p_wet_next = delayed * $signed({1'b0, wet_gain});
    assign p_dry_next = x_s1_reg * $signed({1'b0, dry_gain});

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            p_fb_reg  <= p_fb_next;
            p_wet_reg <= p_wet_next;
            p_dry_reg <= p_dry_next;
            x_s2_reg  <= x_s1_reg;
        end
    end

    // Stage two: drop 15 fraction bits (floor), add, and saturate.
    assign fb_term  = $signed(p_fb_reg[SB+15:15]);
    assign wet_term = $signed(p_wet_reg[SB+16:15]);
    assign dry_term = $signed(p_dry_reg[SB+16:15]);
    assign st_sum   = (SB+2)'(x_s2_reg) + (SB+2)'(fb_term);
    assign out_sum  = (SB+3)'(dry_term) + (SB+3)'(wet_term);

    always_comb
    begin
        if (st_sum > SMAX)
        begin
            store_sample = SMAX;
        end
        else if (st_sum < SMIN)
        begin
            store_sample = SMIN;
        end
        else
        begin
            store_sample = st_sum[SB-1:0];
        end
    end

    always_comb
    begin
        if (out_sum > SMAX)
        begin
            out_sat = SMAX;
        end
        else if (out_sum < SMIN)
        begin
            out_sat = SMIN;
        end
        else
        begin
            out_sat = out_sum[SB-1:0];
        end
    end

    // The output field keeps the low 16 bits of the sign-extended result.
    assign out_ext = (SB+16)'(out_sat);

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_reg <= out_ext[IN_BITS-1:0];
        end
    end

    assign out_sample = out_reg;

endmodule

### rtl/core/stereo_feedback_delay.sv
// Flow: a beat taken at the input is registered in stage one, stage two and the
// output register before its result is offered. Throughput: one frame per clock for
// delays of three frames or more while the output is not stalled; shorter delays hold
// the input while the frame to be read still waits in the pipeline for its write-back.
// Reset: configuration returns to its defaults and the write pointer to zero; the
// RAM is not swept, a wrap flag marks unwritten frames, which read as zero.
`timescale 1ns / 1ps

module stereo_feedback_delay #(
    parameter int MAX_FRAMES  = 131072,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [sfd_pkg::IN_BITS-1:0]    left_in,
    input  logic signed [sfd_pkg::IN_BITS-1:0]    right_in,
    input  logic                                  block_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sfd_pkg::IN_BITS-1:0]    left_out,
    output logic signed [sfd_pkg::IN_BITS-1:0]    right_out,
    output logic                                  block_end_out
);

    import sfd_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int DW = ((AW + 1) > DELAY_W) ? (AW + 1) : DELAY_W;
    localparam int MW = 2 * SAMPLE_BITS;
    localparam logic [DW-1:0] MAX_D    = DW'(MAX_FRAMES);
    localparam logic [AW-1:0] LAST_PTR = AW'(MAX_FRAMES - 1);

    // Configuration registers.
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [FB_W-1:0]    fb_reg, fb_next;
    logic [MIX_W-1:0]   mix_reg, mix_next;

    // Pointer and pipeline control.
    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          s2_valid_reg, s2_valid_next;
    logic          out_valid_reg, out_valid_next;

    // Per-beat side data carried along the pipeline.
    logic [AW-1:0] wp_s1_reg, wp_s2_reg;
    logic          hit_s1_reg;
    logic          be_s1_reg, be_s2_reg, be_out_reg;

    logic [DW-1:0]    d_raw, d_eff, wp_ext, rp_wide;
    logic [AW-1:0]    rd_addr;
    logic [1:0]       inflight;
    logic             hazard, entry_hit;
    logic             in_fire, out_load, s2_free, s1_move, s1_free;
    logic [FB_W-1:0]  fb_eff;
    logic [MIX_W-1:0] wet_eff, dry_eff;
    logic [MW-1:0]    rd_data, wr_data;
    logic signed [SAMPLE_BITS-1:0] store_l, store_r;
    sfd_stage_ctl_t   stage_ctl;

    // Configuration writes; an unknown index is ignored.
    always_comb
    begin
        delay_next = delay_reg;
        fb_next    = fb_reg;
        mix_next   = mix_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_DELAY:    delay_next = cfg_data[DELAY_W-1:0];
                REG_FEEDBACK: fb_next    = cfg_data[FB_W-1:0];
                REG_MIX:      mix_next   = cfg_data[MIX_W-1:0];
                default:      delay_next = delay_reg;
            endcase
        end
    end

    // Clamp the gains and the delay to their legal ranges.
    assign fb_eff  = (fb_reg > FEEDBACK_CAP) ? FEEDBACK_CAP : fb_reg;
    assign wet_eff = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
    assign dry_eff = MIX_ONE - wet_eff;

    always_comb
    begin
        d_raw = DW'(delay_reg);
        if (d_raw == '0)
        begin
            d_eff = DW'(1);
        end
        else if (d_raw > MAX_D)
        begin
            d_eff = MAX_D;
        end
        else
        begin
            d_eff = d_raw;
        end
    end

    // Read address: write pointer minus delay, wrapped into the ring.
    always_comb
    begin
        wp_ext = DW'(wp_reg);
        if (wp_ext >= d_eff)
        begin
            rp_wide = wp_ext - d_eff;
        end
        else
        begin
            rp_wide = wp_ext + MAX_D - d_eff;
        end
    end

    assign rd_addr = rp_wide[AW-1:0];

    // Frames below the write pointer, or any frame once the ring has wrapped,
    // hold written data.
    assign entry_hit = wrapped_reg || (rd_addr < wp_reg);

    // In-flight beats hold the frames just behind the write pointer; a read that
    // lands on one of them waits until its write-back is done.
    assign inflight = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};
    assign hazard   = (d_eff <= DW'(inflight));

    // Pipeline flow: each stage moves when the one after it is free.
    assign out_load = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_free  = !s2_valid_reg || out_load;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_move;
    assign in_ready = s1_free && !hazard;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        wp_next       = wp_reg;
        wrapped_next  = wrapped_reg;
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            if (wp_reg == LAST_PTR)
            begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + 1'b1;
            end
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s2_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= DELAY_RESET;
            fb_reg        <= FB_RESET;
            mix_reg       <= MIX_RESET;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            delay_reg     <= delay_next;
            fb_reg        <= fb_next;
            mix_reg       <= mix_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Side data follows the beat through the stages.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            wp_s1_reg  <= wp_reg;
            hit_s1_reg <= entry_hit;
            be_s1_reg  <= block_end;
        end
        if (s1_move)
        begin
            wp_s2_reg <= wp_s1_reg;
            be_s2_reg <= be_s1_reg;
        end
        if (out_load)
        begin
            be_out_reg <= be_s2_reg;
        end
    end

    // Ring memory: left sample in the upper half, right in the lower half.
    // The frame is written back as its beat leaves the last stage.
    assign wr_data = {store_l, store_r};

    sfd_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_FRAMES)
    ) u_ring (
        .clk     (clk),
        .wr_en   (out_load),
        .wr_addr (wp_s2_reg),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stage_ctl.accept   = in_fire;
    assign stage_ctl.s2_load  = s1_move;
    assign stage_ctl.out_load = out_load;

    sfd_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left (
        .clk          (clk),
        .ctl          (stage_ctl),
        .in_sample    (left_in),
        .mem_sample   ($signed(rd_data[MW-1:SAMPLE_BITS])),
        .entry_hit    (hit_s1_reg),
        .fb_gain      (fb_eff),
        .wet_gain     (wet_eff),
        .dry_gain     (dry_eff),
        .store_sample (store_l),
        .out_sample   (left_out)
    );

    sfd_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
        .clk          (clk),
        .ctl          (stage_ctl),
        .in_sample    (right_in),
        .mem_sample   ($signed(rd_data[SAMPLE_BITS-1:0])),
        .entry_hit    (hit_s1_reg),
        .fb_gain      (fb_eff),
        .wet_gain     (wet_eff),
        .dry_gain     (dry_eff),
        .store_sample (store_r),
        .out_sample   (right_out)
    );

    assign out_valid     = out_valid_reg;
    assign block_end_out = be_out_reg;

`ifndef SYNTHESIS
    // A frame is never read while its write-back is still pending.
    a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !(s1_valid_reg && (rd_addr == wp_s1_reg))
                 && !(s2_valid_reg && (rd_addr == wp_s2_reg)))
        else $error("read of a frame with a pending write-back");

    // The write pointer steps by one frame for each beat taken.
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (wp_reg == (($past(wp_reg) == LAST_PTR) ? '0
                                : AW'($past(wp_reg) + 1'b1))))
        else $error("write pointer did not advance with the beat");

    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(wp_reg))
        else $error("write pointer moved without a beat");

    // Beats in the two stages hold consecutive ring frames.
    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |->
            (wp_s1_reg == ((wp_s2_reg == LAST_PTR) ? '0 : AW'(wp_s2_reg + 1'b1))))
        else $error("pipeline frames out of order");

    // When the fill mark rises, the pointer stands at the start of the ring.
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wrapped_reg) |-> (wp_reg == '0))
        else $error("wrap flag set away from the ring start");
`endif

endmodule
